// ===== rtl/core/mm3_pkg.sv =====
// Shared types, constants and helpers for the MurmurHash3 x86_32 stream hasher.
package mm3_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [31:0] MIX_C1  = 32'hcc9e_2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b87_3593;
    localparam logic [31:0] MIX_ADD = 32'he654_6b64;
    localparam logic [31:0] FIN_C1  = 32'h85eb_ca6b;
    localparam logic [31:0] FIN_C2  = 32'hc2b2_ae35;

    localparam logic [2:0] FULL_BYTES = 3'd4;

    // One classified key word as it travels from front to back.
    typedef struct packed {
        logic [31:0] data;    // tail bytes already masked
        logic [2:0]  nbytes;  // 0..4, always 4 when not last
        logic        last;
        logic        block;   // full 4-byte block: gets the full round
    } t_entry;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

endpackage

// ===== rtl/core/mm3_front.sv =====
// Front end: takes input words, saturates the byte count, masks tail bytes.
module mm3_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_data_word,
    input  logic [2:0]         i_valid_bytes,
    input  logic               i_last_word,
    input  logic               i_full,
    output logic               o_push,
    output mm3_pkg::t_entry    o_entry
);

    logic            r_valid;
    mm3_pkg::t_entry r_ent;
    mm3_pkg::t_entry n_ent;
    logic [2:0]      nb;
    logic [31:0]     mask;
    logic            accept;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_entry = r_ent;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (!i_last_word || i_valid_bytes > mm3_pkg::FULL_BYTES) begin
            nb = mm3_pkg::FULL_BYTES;
        end else begin
            nb = i_valid_bytes;
        end
        case (nb)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
        n_ent.data   = i_data_word & mask;
        n_ent.nbytes = nb;
        n_ent.last   = i_last_word;
        n_ent.block  = (nb == mm3_pkg::FULL_BYTES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent <= n_ent;
        end
    end

endmodule

// ===== rtl/core/mm3_queue.sv =====
// Short word queue between the front end and the mixing sequencer.
module mm3_queue #(
    parameter int unsigned DEPTH = mm3_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mm3_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output mm3_pkg::t_entry o_entry
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    mm3_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== rtl/core/mm3_back.sv =====
// Back end: mixing and finalizer sequencer with the output register.
module mm3_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  mm3_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [31:0]     o_hash_value
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MIX, S_FIN1, S_FIN2, S_OUT
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_k, n_k;
    logic [31:0] r_h, n_h;
    logic [31:0] r_len, n_len;
    logic [2:0]  r_nb, n_nb;
    logic        r_last, n_last;
    logic        r_block, n_block;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out, n_out;
    logic [31:0] t_mix;
    logic [31:0] t_fin;

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_h         = r_h;
        n_len       = r_len;
        n_nb        = r_nb;
        n_last      = r_last;
        n_block     = r_block;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        o_pop       = 1'b0;
        t_mix       = mm3_pkg::rotl13(r_h ^ r_k);
        t_fin       = r_h ^ r_len;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_k     = i_entry.data;
                    n_nb    = i_entry.nbytes;
                    n_last  = i_entry.last;
                    n_block = i_entry.block;
                    // empty last word: only length and finalizer
                    n_state = (i_entry.nbytes == 3'd0) ? S_FIN1 : S_MUL1;
                end
            end
            S_MUL1: begin
                n_k     = r_k * mm3_pkg::MIX_C1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_k     = mm3_pkg::rotl15(r_k) * mm3_pkg::MIX_C2;
                n_state = S_MIX;
            end
            S_MIX: begin
                if (r_block) begin
                    n_h = {t_mix[29:0], 2'b00} + t_mix + mm3_pkg::MIX_ADD;
                end else begin
                    n_h = r_h ^ r_k;
                end
                n_len   = r_len + {29'd0, r_nb};
                n_state = r_last ? S_FIN1 : S_IDLE;
            end
            S_FIN1: begin
                n_h     = (t_fin ^ {16'd0, t_fin[31:16]}) * mm3_pkg::FIN_C1;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                n_h     = (r_h ^ {13'd0, r_h[31:13]}) * mm3_pkg::FIN_C2;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out       = r_h ^ {16'd0, r_h[31:16]};
                    n_out_valid = 1'b1;
                    n_h         = '0;
                    n_len       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_h         <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_h         <= n_h;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_k     <= n_k;
        r_nb    <= n_nb;
        r_last  <= n_last;
        r_block <= n_block;
        r_out   <= n_out;
    end

endmodule

// ===== rtl/core/murmur3_32_stream_hash.sv =====
// Top level: MurmurHash3 x86_32 (seed zero) over a stream of key words.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+--------------------------------------
//  in      | in  | i_in_valid / o_in_stall    | i_data_word, i_valid_bytes, i_last_word
//  out     | out | o_out_valid / i_out_stall  | o_hash_value
//
// A word with 1..4 bytes passes through the mixing sequencer's steps in order
// (pop, two multiply stages, mix); an empty last word skips to the finalizer.
// A last word adds two finalizer multiply stages and the output load.
// The back-end sequencer takes a new word only once it is through with the last;
// the front register and queue absorb bursts of QUEUE_DEPTH + 1 words.
// Reset is synchronous, active low; it empties the queue and clears the
// running hash and byte count. An output stall holds the result register;
// the sequencer waits in its output step only while that register is full
// and stalled.
module murmur3_32_stream_hash #(
    parameter int unsigned QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);

    // front register -> queue
    logic            push;
    logic            q_full;
    mm3_pkg::t_entry front_entry;

    // queue -> sequencer
    logic            pop;
    logic            q_empty;
    mm3_pkg::t_entry head_entry;

    mm3_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .i_full        (q_full),
        .o_push        (push),
        .o_entry       (front_entry)
    );

    mm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_entry (head_entry)
    );

    // sequencer owns the running hash, byte count and result register
    mm3_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_entry      (head_entry),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_hash_value (o_hash_value)
    );

endmodule

// ===== rtl/core/mm3_check.sv =====
// Port-level checker for the stream hasher, bound to the top level.
module mm3_check #(
    parameter int unsigned QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_last_word,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_hash_value
);

    localparam int unsigned MAX_KEYS = QUEUE_DEPTH + 3;
    localparam int unsigned PW = $clog2(MAX_KEYS + 2) + 1;

    logic [PW-1:0] r_pend;
    logic          key_in;
    logic          key_out;

    assign key_in  = i_in_valid && !o_in_stall && i_last_word;
    assign key_out = o_out_valid && !i_out_stall;

    // keys whose last word went in but whose hash has not come out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (key_in && !key_out) begin
            r_pend <= r_pend + 1'b1;
        end else if (key_out && !key_in && r_pend != '0) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hash_value))
        else $error("stalled result dropped or changed");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != '0)
        else $error("result without a finished key");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PW'(MAX_KEYS))
        else $error("more keys in flight than storage allows");

endmodule

bind murmur3_32_stream_hash mm3_check #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mm3_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_last_word  (i_last_word),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_hash_value (o_hash_value)
);

// ===== dv/mm3_hash_checker.sv =====
// Checker for the MurmurHash3 stream hasher: watches both channels, predicts and compares.
module mm3_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_hash_value,
    input  logic        i_final_check,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_keys_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] K_MUL1   = 32'hcc9e_2d51;
    localparam logic [31:0] K_MUL2   = 32'h1b87_3593;
    localparam logic [31:0] K_ROUND  = 32'he654_6b64;
    localparam logic [31:0] K_FMIX1  = 32'h85eb_ca6b;
    localparam logic [31:0] K_FMIX2  = 32'hc2b2_ae35;
    localparam logic [2:0]  BLOCK_BYTES = 3'd4;

    logic [31:0] hash_acc;
    logic [31:0] key_bytes;
    logic [31:0] key_hashes[$];
    int          fails;
    int          keys_done;
    bit          final_done;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * K_MUL1;
        t = rotl(t, 15);
        return t * K_MUL2;
    endfunction

    function automatic logic [31:0] fmix32(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * K_FMIX1;
        t = t ^ (t >> 13);
        t = t * K_FMIX2;
        return t ^ (t >> 16);
    endfunction

    initial begin
        hash_acc   = '0;
        key_bytes  = '0;
        fails      = 0;
        keys_done  = 0;
        final_done = 1'b0;
    end

    always @(posedge i_clk) begin
        logic [2:0]  nb;
        logic [31:0] want;
        if (!i_rst_n) begin
            hash_acc  = '0;
            key_bytes = '0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                nb = (i_valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : i_valid_bytes;
                if (!i_last_word || nb == BLOCK_BYTES) begin
                    hash_acc  = rotl(hash_acc ^ scramble_word(i_data_word), 13);
                    hash_acc  = hash_acc * 32'd5 + K_ROUND;
                    key_bytes = key_bytes + 32'd4;
                end else if (nb != 3'd0) begin
                    // tail: bytes past the count are zeroed, no round step
                    hash_acc  = hash_acc ^
                                scramble_word(i_data_word & ((32'h1 << (8 * nb)) - 32'h1));
                    key_bytes = key_bytes + 32'(nb);
                end
                if (i_last_word) begin
                    key_hashes.push_back(fmix32(hash_acc ^ key_bytes));
                    hash_acc  = '0;
                    key_bytes = '0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (key_hashes.size() == 0) begin
                    $error("hash_value: expected none, actual 0x%08h", i_hash_value);
                    fails++;
                end else begin
                    want = key_hashes.pop_front();
                    keys_done++;
                    if (i_hash_value !== want) begin
                        $error("hash_value: expected 0x%08h, actual 0x%08h", want, i_hash_value);
                        fails++;
                    end
                end
            end
            if (i_final_check && !final_done) begin
                final_done = 1'b1;
                if (key_hashes.size() != 0) begin
                    $error("hash_value: expected %0d more, actual none", key_hashes.size());
                    fails += key_hashes.size();
                end
            end
        end
        o_fail_count   = fails;
        o_pending      = key_hashes.size();
        o_keys_checked = keys_done;
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the MurmurHash3 stream hasher bench: clock, reset, word stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Word count per random phase; four phases give roughly 1600 words.
    localparam int PHASE_WORDS   = 400;
    // Deepest drain: front reg + queue through the mixing steps, plus the finalizer.
    localparam int SETTLE_CYCLES = 60;
    // Long output hold-off, long enough to back the queue up to the input.
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam logic [2:0] BLOCK_BYTES = 3'd4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_data_word;
    logic [2:0]  i_valid_bytes;
    logic        i_last_word;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_hash_value;
    logic        final_check;

    int fail_count;
    int pending;
    int keys_checked;

    // Idle profile of the current phase, in percent of cycles.
    int tx_idle_pct;
    int rx_stall_pct;
    // Long hold-off handshake between stimulus and the receiver process.
    int hold_requests;
    int holds_served;
    int words_sent;
    int cycles;

    murmur3_32_stream_hash dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hash_value  (o_hash_value)
    );

    mm3_hash_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_word    (i_data_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_last_word    (i_last_word),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_hash_value   (o_hash_value),
        .i_final_check  (final_check),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_keys_checked (keys_checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("murmur3_32_stream_hash regression: fail");
        $finish;
    end

    // Receiver: random stall per phase, or a long counted hold-off on request.
    initial begin
        i_out_stall  = 1'b0;
        holds_served = 0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                i_out_stall = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                holds_served++;
            end else begin
                i_out_stall = ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Offer one word and hold it until accepted; then maybe leave a gap,
    // scribbling on the payload while valid is low. Each cycle of the gap
    // is idle with the phase's idle probability.
    task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_data_word   = w;
        i_valid_bytes = nb;
        i_last_word   = lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid    = 1'b0;
            i_data_word   = $urandom;
            i_valid_bytes = 3'($urandom_range(7));
            i_last_word   = 1'($urandom_range(1));
            while ($urandom_range(99) < tx_idle_pct) @(negedge i_clk);
        end
    endtask

    // One key: mostly short, a few long; a random tail on the last word.
    task automatic send_random_key();
        int          pick;
        int          nfull;
        logic [2:0]  tail;
        pick = $urandom_range(99);
        if (pick < 10)
            nfull = 0;
        else if (pick < 85)
            nfull = $urandom_range(1, 6);
        else if (pick < 97)
            nfull = $urandom_range(7, 20);
        else
            nfull = $urandom_range(30, 64);
        repeat (nfull) begin
            // byte count is don't-care before the last word; mostly 4, sometimes junk
            send_word($urandom,
                      ($urandom_range(99) < 80) ? BLOCK_BYTES : 3'($urandom_range(7)),
                      1'b0);
        end
        // counts 5..7 on the last word should saturate to a full block
        tail = ($urandom_range(99) < 88) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
        send_word($urandom, tail, 1'b1);
    endtask

    // Stop offering and wait until every predicted hash has come out.
    task automatic wait_for_hashes();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int phase_start;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_word   = '0;
        i_valid_bytes = '0;
        i_last_word   = 1'b0;
        final_check   = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_requests = 0;
        words_sent    = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corners, back to back, no idling.
        // Empty key: only length and finalizer; data must be ignored.
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'hffff_ffff, 3'd0, 1'b1);
        // Single-word keys, each tail size, bytes above the count set.
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'hffff_ffff, 3'd2, 1'b1);
        // High bits set in every byte: tail bytes are unsigned.
        send_word(32'h8080_8080, 3'd3, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        // Oversized counts saturate to four.
        send_word(32'h1234_5678, 3'd5, 1'b1);
        send_word(32'h8765_4321, 3'd6, 1'b1);
        send_word(32'hdead_beef, 3'd7, 1'b1);
        // Count ignored on non-last words, extremes of it.
        send_word(32'h0000_0000, 3'd0, 1'b0);
        send_word(32'h0000_00ff, 3'd3, 1'b1);
        send_word(32'hffff_ffff, 3'd7, 1'b0);
        send_word(32'hffff_ffff, 3'd0, 1'b1);
        // Multi-word all-ones key.
        send_word(32'hffff_ffff, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        wait_for_hashes();

        // Random phases: no idling (with the long hold-off), sender idle,
        // receiver stalling, both lightly.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    hold_requests++;
                end
                1: begin
                    tx_idle_pct  = 70;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 70;
                end
                default: begin
                    tx_idle_pct  = 9;
                    rx_stall_pct = 9;
                end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) send_random_key();
            // sender pauses here until the block has emitted everything
            wait_for_hashes();
        end

        @(negedge i_clk);
        final_check = 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);

        $display("covered %0d words over %0d keys: corner tails, saturated counts,",
                 words_sent, keys_checked);
        $display("four idle profiles and a long output hold-off with input backpressure");
        if (fail_count == 0)
            $display("murmur3_32_stream_hash regression: pass");
        else
            $display("murmur3_32_stream_hash regression: fail");
        $finish;
    end

endmodule
